// File: design/rwcs_pkg.sv
// rwcs_pkg: shared types and constants of the wall column span generator
// used by rwcs_divider and raycast_wall_column_spans
// no dependencies
package rwcs_pkg;

  // fixed field widths
  localparam int DIST_W   = 24;
  localparam int COORD_W  = 16;
  localparam int COLOR_W  = 24;
  localparam int COL_W    = 10;
  localparam int ROWO_W   = 10;
  localparam int TEXQ_W   = 23;
  localparam int TCOL_W   = 6;
  localparam int HEIGHT_W = 16;
  localparam int HALF_W   = 15;
  localparam int CFG_IDX_W = 2;

  // shared divider: divisor / remainder width, quotient shift width, step count width
  localparam int DIV_W  = 24;
  localparam int QUO_W  = 23;
  localparam int STEP_W = 5;

  // step counts of the three divisions
  localparam logic [STEP_W-1:0] HEIGHT_STEPS = 5'd16;
  localparam logic [STEP_W-1:0] TSTEP_STEPS  = 5'd23;
  localparam logic [STEP_W-1:0] TSTART_STEPS = 5'd22;

  // 64.0 in Q7.16
  localparam logic [QUO_W-1:0] TEX_ONE_Q16 = 23'h400000;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 16'hFFFF;

  localparam logic [DIV_W-1:0] PROJ_SCALE_RESET = 24'd35473;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROJECTION_SCALE = 2'd0,
    REG_CEILING_COLOR    = 2'd1,
    REG_FLOOR_COLOR      = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_CEILING = 2'd0,
    KIND_WALL    = 2'd1,
    KIND_FLOOR   = 2'd2
  } span_kind_t;

  typedef enum logic [1:0] {
    TEX_WEST  = 2'd0,
    TEX_EAST  = 2'd1,
    TEX_SOUTH = 2'd2,
    TEX_NORTH = 2'd3
  } tex_face_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAUNCH_H,
    ST_WAIT_H,
    ST_GEOM,
    ST_LAUNCH_STEP,
    ST_WAIT_STEP,
    ST_LAUNCH_START,
    ST_WAIT_START,
    ST_EMIT_CEIL,
    ST_EMIT_WALL,
    ST_EMIT_FLOOR
  } state_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [COLOR_W-1:0]   value;
  } cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic               hit_vertical;
    logic [COORD_W-1:0] hit_x;
    logic [COORD_W-1:0] hit_y;
    logic               facing_left;
    logic               facing_up;
  } ray_t;

  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [1:0]         span_kind;
    logic [ROWO_W-1:0]  row_start;
    logic [ROWO_W-1:0]  row_end;
    logic [COLOR_W-1:0] fill_color;
    logic [1:0]         texture_select;
    logic [TCOL_W-1:0]  tex_column;
    logic [TEXQ_W-1:0]  tex_row_start;
    logic [TEXQ_W-1:0]  tex_row_step;
    logic               last;
  } span_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: design/rwcs_chan_if.sv
// rwcs_chan_if: valid/ready channel carrying one payload item
// payload type is set per instance; types come from rwcs_pkg
interface rwcs_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/rwcs_divider.sv
// rwcs_divider: radix-2 restoring divider, one quotient bit per cycle
// caller preloads the partial remainder and left-aligns the dividend bits
// depends on rwcs_pkg
module rwcs_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  rwcs_pkg::div_ctrl_t             ctrl,
  input  logic [rwcs_pkg::DIV_W-1:0]      divisor,
  input  logic [rwcs_pkg::DIV_W-1:0]      rem_init,
  input  logic [rwcs_pkg::QUO_W-1:0]      num,
  output rwcs_pkg::div_status_t           status,
  output logic [rwcs_pkg::QUO_W-1:0]      quotient
);
  import rwcs_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] count;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  rem_next;
  logic [DIV_W-1:0]  dvsr;
  logic [QUO_W-1:0]  shreg;
  logic [DIV_W:0]    partial;
  logic [DIV_W+1:0]  diff;
  logic              qbit;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    partial  = {rem, shreg[QUO_W-1]};
    diff     = {1'b0, partial} - {2'b00, dvsr};
    qbit     = ~diff[DIV_W+1];
    rem_next = qbit ? diff[DIV_W-1:0] : partial[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy  <= 1'b1;
        count <= ctrl.steps;
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem   <= rem_init;
      dvsr  <= divisor;
      shreg <= num;
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= {shreg[QUO_W-2:0], qbit};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = shreg;

endmodule

// File: design/raycast_wall_column_spans.sv
// raycast_wall_column_spans: one ray hit in, ceiling, wall and floor spans out
// sequence: strip height on the shared radix-2 divider, geometry, texture step, texture start,
//   then the ceiling span; saturated height skips the height division, no rows cut off
//   above the screen skips texture start, zero height skips both texture divisions
// ray.ready only in idle: a new ray waits until all three spans of the last one are taken
// reset: synchronous rst clears sequencer and column, projection_scale 35473, colors 0
module raycast_wall_column_spans #(
  parameter int SCREEN_HEIGHT = 512,
  parameter int SCREEN_WIDTH  = 640,
  parameter int TILE_PIXELS   = 64
) (
  input  logic               clk,
  input  logic               rst,
  rwcs_chan_if.sink          cfg,
  rwcs_chan_if.sink          ray,
  rwcs_chan_if.source        span
);
  import rwcs_pkg::*;

  localparam int ROW_W = $clog2(SCREEN_HEIGHT + 1);
  localparam int MID   = SCREEN_HEIGHT / 2;

  // reciprocal of the tile size, exact quotient for every 16-bit coordinate
  localparam int RECIP_W    = COORD_W + 1;
  localparam int PROD_W     = 2 * COORD_W + 1;
  localparam int TILE_SHIFT = COORD_W + $clog2(TILE_PIXELS);
  localparam logic [RECIP_W-1:0] TILE_RECIP =
    RECIP_W'(((64'd1 << TILE_SHIFT) + 64'(TILE_PIXELS) - 64'd1) / 64'(TILE_PIXELS));
  localparam logic [COORD_W-1:0] TILE_LEN = COORD_W'(TILE_PIXELS);

  state_t state;
  state_t state_next;

  // configuration registers
  logic [DIST_W-1:0]  proj_scale;
  logic [COLOR_W-1:0] ceil_color;
  logic [COLOR_W-1:0] floor_color;

  // per-ray working registers
  logic [COL_W-1:0]    column;
  logic [COL_W-1:0]    column_next;
  logic [COL_W:0]      column_inc;
  logic [DIST_W-1:0]   ray_dist;
  logic [1:0]          tsel;
  logic [COORD_W-1:0]  coord;
  logic [COORD_W-1:0]  tile_quo;
  logic [TCOL_W-1:0]   tcol;
  logic [HEIGHT_W-1:0] height;
  logic [ROW_W-1:0]    top;
  logic [ROW_W-1:0]    bot;
  logic [HALF_W-1:0]   dft;
  logic [TEXQ_W-1:0]   tstep;
  logic [TEXQ_W-1:0]   tstart;

  // geometry from the strip height
  logic [31:0]         half_ext;
  logic [31:0]         bot_sum;
  logic [ROW_W-1:0]    top_val;
  logic [ROW_W-1:0]    bot_val;
  logic [HALF_W-1:0]   dft_val;
  logic                saturate;
  logic [COORD_W-1:0]  coord_in;
  logic [1:0]          tsel_in;
  logic [PROD_W-1:0]   tile_prod;
  logic [COORD_W-1:0]  tile_rem;

  // shared divider hookup
  div_ctrl_t          div_ctrl;
  div_status_t        div_stat;
  logic [DIV_W-1:0]   div_divisor;
  logic [DIV_W-1:0]   div_rem_init;
  logic [QUO_W-1:0]   div_num;
  logic [QUO_W-1:0]   div_quo;

  rwcs_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .divisor   (div_divisor),
    .rem_init  (div_rem_init),
    .num       (div_num),
    .status    (div_stat),
    .quotient  (div_quo)
  );

  // config writes, always taken; unknown index is dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      proj_scale  <= PROJ_SCALE_RESET;
      ceil_color  <= '0;
      floor_color <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_PROJECTION_SCALE: proj_scale  <= cfg.data.value;
        REG_CEILING_COLOR:    ceil_color  <= cfg.data.value;
        REG_FLOOR_COLOR:      floor_color <= cfg.data.value;
        default: ;
      endcase
    end
  end

  // texture face and the coordinate whose tile remainder gives the column
  always_comb begin
    if (ray.data.hit_vertical) begin
      coord_in = ray.data.hit_y;
      tsel_in  = ray.data.facing_left ? TEX_WEST : TEX_EAST;
    end else begin
      coord_in = ray.data.hit_x;
      tsel_in  = ray.data.facing_up ? TEX_SOUTH : TEX_NORTH;
    end
  end

  // tile remainder: quotient by reciprocal multiply, registered, then one
  // multiply-subtract by the tile size
  assign tile_prod = PROD_W'(coord) * PROD_W'(TILE_RECIP);
  assign tile_rem  = coord - tile_quo * TILE_LEN;

  // quotient overflows 16 bits exactly when scale >= distance * 256;
  // this also covers zero distance
  assign saturate = ({8'd0, proj_scale} >= {ray_dist, 8'd0});

  // wall centered on the middle row, clamped to the screen
  always_comb begin
    half_ext = 32'(height[HEIGHT_W-1:1]);
    bot_sum  = 32'(MID) + half_ext;
    if (half_ext >= 32'(MID)) begin
      top_val = '0;
      dft_val = HALF_W'(half_ext - 32'(MID));
    end else begin
      top_val = ROW_W'(32'(MID) - half_ext);
      dft_val = '0;
    end
    bot_val = (bot_sum > 32'(SCREEN_HEIGHT)) ? ROW_W'(SCREEN_HEIGHT) : ROW_W'(bot_sum);
  end

  // column counter wraps at the mask width and at the screen width
  always_comb begin
    column_inc  = {1'b0, column} + 1'b1;
    column_next = column_inc[COL_W-1:0];
    if (32'(column_next) >= 32'(SCREEN_WIDTH)) begin
      column_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      column <= '0;
    end else begin
      state <= state_next;
      if (span.valid && span.ready && state == ST_EMIT_FLOOR) begin
        column <= column_next;
      end
    end
  end

  // working registers, loaded as each step of the sequence finishes
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && ray.valid) begin
      ray_dist <= ray.data.distance;
      tsel     <= tsel_in;
      coord    <= coord_in;
    end
    if (state == ST_LAUNCH_H) begin
      tile_quo <= COORD_W'(tile_prod >> TILE_SHIFT);
    end
    if (state == ST_LAUNCH_H && saturate) begin
      height <= HEIGHT_MAX;
    end
    if (state == ST_WAIT_H && div_stat.done) begin
      height <= div_quo[HEIGHT_W-1:0];
    end
    if (state == ST_GEOM) begin
      top    <= top_val;
      bot    <= bot_val;
      dft    <= dft_val;
      tcol   <= TCOL_W'(tile_rem);
      tstep  <= '0;
      tstart <= '0;
    end
    if (state == ST_WAIT_STEP && div_stat.done) begin
      tstep <= div_quo;
    end
    if (state == ST_WAIT_START && div_stat.done) begin
      tstart <= div_quo;
    end
  end

  // sequencer: drives the divider and the span channel
  always_comb begin
    state_next   = state;
    ray.ready    = 1'b0;
    span.valid   = 1'b0;
    div_ctrl     = '0;
    div_divisor  = '0;
    div_rem_init = '0;
    div_num      = '0;

    span.data.column         = column;
    span.data.span_kind      = KIND_CEILING;
    span.data.row_start      = '0;
    span.data.row_end        = ROWO_W'(top);
    span.data.fill_color     = ceil_color;
    span.data.texture_select = '0;
    span.data.tex_column     = '0;
    span.data.tex_row_start  = '0;
    span.data.tex_row_step   = '0;
    span.data.last           = 1'b0;

    unique case (state)
      ST_IDLE: begin
        ray.ready = 1'b1;
        if (ray.valid) state_next = ST_LAUNCH_H;
      end
      ST_LAUNCH_H: begin
        if (saturate) begin
          state_next = ST_GEOM;
        end else begin
          // scale*256/dist with a 16-bit quotient: upper bits preloaded
          div_ctrl.start = 1'b1;
          div_ctrl.steps = HEIGHT_STEPS;
          div_divisor    = ray_dist;
          div_rem_init   = {8'd0, proj_scale[DIST_W-1:8]};
          div_num        = {proj_scale[7:0], 15'd0};
          state_next     = ST_WAIT_H;
        end
      end
      ST_WAIT_H: begin
        if (div_stat.done) state_next = ST_GEOM;
      end
      ST_GEOM: begin
        state_next = (height == '0) ? ST_EMIT_CEIL : ST_LAUNCH_STEP;
      end
      ST_LAUNCH_STEP: begin
        // 64.0 / height
        div_ctrl.start = 1'b1;
        div_ctrl.steps = TSTEP_STEPS;
        div_divisor    = DIV_W'(height);
        div_num        = TEX_ONE_Q16;
        state_next     = ST_WAIT_STEP;
      end
      ST_WAIT_STEP: begin
        if (div_stat.done) begin
          state_next = (dft == '0) ? ST_EMIT_CEIL : ST_LAUNCH_START;
        end
      end
      ST_LAUNCH_START: begin
        // rows cut off above the screen times 64.0 / height; dft < height
        div_ctrl.start = 1'b1;
        div_ctrl.steps = TSTART_STEPS;
        div_divisor    = DIV_W'(height);
        div_rem_init   = DIV_W'(dft);
        state_next     = ST_WAIT_START;
      end
      ST_WAIT_START: begin
        if (div_stat.done) state_next = ST_EMIT_CEIL;
      end
      ST_EMIT_CEIL: begin
        span.valid = 1'b1;
        if (span.ready) state_next = ST_EMIT_WALL;
      end
      ST_EMIT_WALL: begin
        span.valid               = 1'b1;
        span.data.span_kind      = KIND_WALL;
        span.data.row_start      = ROWO_W'(top);
        span.data.row_end        = ROWO_W'(bot);
        span.data.fill_color     = '0;
        span.data.texture_select = tsel;
        span.data.tex_column     = tcol;
        span.data.tex_row_start  = tstart;
        span.data.tex_row_step   = tstep;
        if (span.ready) state_next = ST_EMIT_FLOOR;
      end
      ST_EMIT_FLOOR: begin
        span.valid           = 1'b1;
        span.data.span_kind  = KIND_FLOOR;
        span.data.row_start  = ROWO_W'(bot);
        span.data.row_end    = ROWO_W'(SCREEN_HEIGHT);
        span.data.fill_color = floor_color;
        span.data.last       = 1'b1;
        if (span.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  // no new ray while a span of the current one is still pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ray.ready && span.valid))
    else $error("ray accepted while spans pending");

  // divider is never restarted mid-division
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_ctrl.start |-> !div_stat.busy)
    else $error("divider started while busy");

  // divider results only arrive while the sequencer waits for them
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == ST_WAIT_H || state == ST_WAIT_STEP ||
                       state == ST_WAIT_START))
    else $error("divider done outside a wait state");

  // wall span is never inverted
  a_wall_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_WALL) |-> (top <= bot))
    else $error("wall span start after end");

  // the column moves on once the floor span is taken
  a_column_adv: assert property (@(posedge clk) disable iff (rst)
    (span.valid && span.ready && state == ST_EMIT_FLOOR) |=> !$stable(column))
    else $error("column did not advance");
`endif

endmodule
